// File: src/sgi_pkg.sv
`default_nettype none

package sgi_pkg;

    // default coordinate width, two's complement
    localparam int COORD_WIDTH_DEF = 32;

    // divider sizing that follows from the coordinate width
    localparam int DIV_QW_DEF = COORD_WIDTH_DEF;
    localparam int DIV_DW_DEF = 2 * COORD_WIDTH_DEF + 2;

endpackage

`default_nettype wire

// File: src/sgi_div.sv
`default_nettype none

module sgi_div #(
    parameter int QW = sgi_pkg::DIV_QW_DEF,
    parameter int DW = sgi_pkg::DIV_DW_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [DW+QW-1:0]   i_num,
    input  wire logic [DW-1:0]      i_den,
    output logic                    o_valid,
    output logic [QW-1:0]           o_quo
);
    import sgi_pkg::*;

    // stage k holds the partial remainder before quotient bit QW-1-k
    logic [DW-1:0] r_rem [QW+1];
    logic [DW-1:0] r_den [QW+1];
    logic [QW-1:0] r_low [QW+1];
    logic [QW-1:0] r_quo [QW+1];
    logic          r_vld [QW+1];

    // entry stage: top bits of the dividend are already below the divisor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num[DW+QW-1:QW];
        r_low[0] <= i_num[QW-1:0];
        r_den[0] <= i_den;
        r_quo[0] <= '0;
    end

    // one restoring step per stage
    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW:0]   trial;
        logic [DW+1:0] diff;
        logic          ge;

        always_comb begin
            trial = {r_rem[k], r_low[k][QW-1]};
            diff  = {1'b0, trial} - {2'b00, r_den[k]};
            ge    = ~diff[DW+1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_low[k+1] <= {r_low[k][QW-2:0], 1'b0};
            r_den[k+1] <= r_den[k];
            r_quo[k+1] <= {r_quo[k][QW-2:0], ge};
        end
    end

    assign o_valid = r_vld[QW];
    assign o_quo   = r_quo[QW];

endmodule

`default_nettype wire

// File: src/segment_intersection_top.sv
`default_nettype none

// Segment intersection pipeline. Each transaction carries two segments as
// endpoint pairs; exactly one result follows per transaction, marked by
// o_done for one cycle. o_done and the result are registered together at
// the output register. A new transaction is taken every cycle, so busy
// stays low; the result cannot be held off and must be captured in the
// cycle o_done is high. The crossing point is rounded by a restoring
// divider (an entry stage and one stage per coordinate bit), which sits
// behind six pipeline stages and ahead of the output register. Parallel,
// collinear and point cases are resolved exactly; the point is reported
// rounded to nearest, ties away from zero.
module segment_intersection_top #(
    parameter int COORD_WIDTH = sgi_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic signed [COORD_WIDTH-1:0]  i_a_start_x,
    input  wire logic signed [COORD_WIDTH-1:0]  i_a_start_y,
    input  wire logic signed [COORD_WIDTH-1:0]  i_a_end_x,
    input  wire logic signed [COORD_WIDTH-1:0]  i_a_end_y,
    input  wire logic signed [COORD_WIDTH-1:0]  i_b_start_x,
    input  wire logic signed [COORD_WIDTH-1:0]  i_b_start_y,
    input  wire logic signed [COORD_WIDTH-1:0]  i_b_end_x,
    input  wire logic signed [COORD_WIDTH-1:0]  i_b_end_y,
    output logic                                o_done,
    output logic                                o_hit,
    output logic                                o_point_valid,
    output logic signed [COORD_WIDTH-1:0]       o_cross_x,
    output logic signed [COORD_WIDTH-1:0]       o_cross_y
);
    import sgi_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int CW    = 2 * W + 2;
    localparam int DEN_W = 2 * W + 1;
    localparam int DVW   = 2 * W + 2;
    localparam int NW    = DVW + W;

    typedef struct packed {
        logic                 hit;
        logic                 pv;
        logic                 slope;
        logic                 neg_x;
        logic                 neg_y;
        logic signed [W-1:0]  base_x;
        logic signed [W-1:0]  base_y;
    } t_side;

    assign busy = 1'b0;

    // ---------------- stage 1: capture the transaction
    logic                r1_vld;
    logic signed [W-1:0] r1_v [8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_v[0] <= i_a_start_x;
        r1_v[1] <= i_a_start_y;
        r1_v[2] <= i_a_end_x;
        r1_v[3] <= i_a_end_y;
        r1_v[4] <= i_b_start_x;
        r1_v[5] <= i_b_start_y;
        r1_v[6] <= i_b_end_x;
        r1_v[7] <= i_b_end_y;
    end

    // ---------------- stage 2: direction vectors and classification
    logic signed [W:0] n2_rx, n2_ry, n2_sx, n2_sy, n2_dx, n2_dy;
    logic              n2_av, n2_ap, n2_ah, n2_bv, n2_bp, n2_bh;

    always_comb begin
        n2_rx = {r1_v[2][W-1], r1_v[2]} - {r1_v[0][W-1], r1_v[0]};
        n2_ry = {r1_v[3][W-1], r1_v[3]} - {r1_v[1][W-1], r1_v[1]};
        n2_sx = {r1_v[6][W-1], r1_v[6]} - {r1_v[4][W-1], r1_v[4]};
        n2_sy = {r1_v[7][W-1], r1_v[7]} - {r1_v[5][W-1], r1_v[5]};
        n2_dx = {r1_v[4][W-1], r1_v[4]} - {r1_v[0][W-1], r1_v[0]};
        n2_dy = {r1_v[5][W-1], r1_v[5]} - {r1_v[1][W-1], r1_v[1]};
        n2_av = r1_v[0] == r1_v[2];
        n2_ap = n2_av && (r1_v[1] == r1_v[3]);
        n2_ah = !n2_av && (r1_v[1] == r1_v[3]);
        n2_bv = r1_v[4] == r1_v[6];
        n2_bp = n2_bv && (r1_v[5] == r1_v[7]);
        n2_bh = !n2_bv && (r1_v[5] == r1_v[7]);
    end

    logic              r2_vld;
    logic signed [W:0] r2_rx, r2_ry, r2_sx, r2_sy, r2_dx, r2_dy, r2_ex, r2_ey;
    logic              r2_ap, r2_bp, r2_vv, r2_hh, r2_eqx, r2_eqy;
    logic signed [W-1:0] r2_bx, r2_by;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_rx  <= n2_rx;
        r2_ry  <= n2_ry;
        r2_sx  <= n2_sx;
        r2_sy  <= n2_sy;
        r2_dx  <= n2_dx;
        r2_dy  <= n2_dy;
        // the segment a point is tested against
        r2_ex  <= n2_ap ? n2_sx : n2_rx;
        r2_ey  <= n2_ap ? n2_sy : n2_ry;
        r2_ap  <= n2_ap;
        r2_bp  <= n2_bp;
        r2_vv  <= n2_av && n2_bv;
        r2_hh  <= n2_ah && n2_bh;
        r2_eqx <= r1_v[0] == r1_v[4];
        r2_eqy <= r1_v[1] == r1_v[5];
        r2_bx  <= (n2_bp && !n2_ap) ? r1_v[4] : r1_v[0];
        r2_by  <= (n2_bp && !n2_ap) ? r1_v[5] : r1_v[1];
    end

    // ---------------- stage 3: products
    logic [W:0] n3_arx, n3_ary;

    always_comb begin
        n3_arx = r2_rx[W] ? -r2_rx : r2_rx;
        n3_ary = r2_ry[W] ? -r2_ry : r2_ry;
    end

    logic                 r3_vld;
    logic signed [CW-1:0] r3_rxsy, r3_rysx, r3_dxsy, r3_dysx, r3_dxry, r3_dyrx;
    logic signed [CW-1:0] r3_dxex, r3_dyey, r3_exex, r3_eyey;
    logic                 r3_ap, r3_bp, r3_vv, r3_hh, r3_eqx, r3_eqy, r3_ez, r3_dz;
    logic                 r3_nx, r3_ny;
    logic [W-1:0]         r3_arx, r3_ary;
    logic signed [W-1:0]  r3_bx, r3_by;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_rxsy <= r2_rx * r2_sy;
        r3_rysx <= r2_ry * r2_sx;
        r3_dxsy <= r2_dx * r2_sy;
        r3_dysx <= r2_dy * r2_sx;
        r3_dxry <= r2_dx * r2_ry;
        r3_dyrx <= r2_dy * r2_rx;
        r3_dxex <= r2_dx * r2_ex;
        r3_dyey <= r2_dy * r2_ey;
        r3_exex <= r2_ex * r2_ex;
        r3_eyey <= r2_ey * r2_ey;
        r3_ap   <= r2_ap;
        r3_bp   <= r2_bp;
        r3_vv   <= r2_vv;
        r3_hh   <= r2_hh;
        r3_eqx  <= r2_eqx;
        r3_eqy  <= r2_eqy;
        r3_ez   <= (r2_ex == '0) && (r2_ey == '0);
        r3_dz   <= (r2_dx == '0) && (r2_dy == '0);
        r3_nx   <= r2_rx[W];
        r3_ny   <= r2_ry[W];
        r3_arx  <= n3_arx[W-1:0];
        r3_ary  <= n3_ary[W-1:0];
        r3_bx   <= r2_bx;
        r3_by   <= r2_by;
    end

    // ---------------- stage 4: cross and dot products
    logic                 r4_vld;
    logic signed [CW-1:0] r4_den, r4_tn, r4_un, r4_g, r4_len;
    logic                 r4_ap, r4_bp, r4_vv, r4_hh, r4_eqx, r4_eqy, r4_ez, r4_dz;
    logic                 r4_nx, r4_ny;
    logic [W-1:0]         r4_arx, r4_ary;
    logic signed [W-1:0]  r4_bx, r4_by;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_den <= r3_rxsy - r3_rysx;
        r4_tn  <= r3_dxsy - r3_dysx;
        r4_un  <= r3_dxry - r3_dyrx;
        r4_g   <= r3_dxex + r3_dyey;
        r4_len <= r3_exex + r3_eyey;
        r4_ap  <= r3_ap;
        r4_bp  <= r3_bp;
        r4_vv  <= r3_vv;
        r4_hh  <= r3_hh;
        r4_eqx <= r3_eqx;
        r4_eqy <= r3_eqy;
        r4_ez  <= r3_ez;
        r4_dz  <= r3_dz;
        r4_nx  <= r3_nx;
        r4_ny  <= r3_ny;
        r4_arx <= r3_arx;
        r4_ary <= r3_ary;
        r4_bx  <= r3_bx;
        r4_by  <= r3_by;
    end

    // ---------------- stage 5: case decision and bound tests
    logic signed [CW-1:0] n5_den, n5_tn, n5_un, n5_nlen;
    logic                 n5_hit, n5_pv, n5_slope;

    always_comb begin
        n5_den   = r4_den[CW-1] ? -r4_den : r4_den;
        n5_tn    = r4_den[CW-1] ? -r4_tn  : r4_tn;
        n5_un    = r4_den[CW-1] ? -r4_un  : r4_un;
        n5_nlen  = -r4_len;
        n5_hit   = 1'b0;
        n5_pv    = 1'b0;
        n5_slope = 1'b0;
        if (r4_ap) begin
            // point a against segment b, direction taken from b
            n5_hit = r4_ez ? r4_dz
                           : (r4_tn == '0) && (r4_g <= 0) && (r4_g >= n5_nlen);
            n5_pv  = n5_hit;
        end else if (r4_bp) begin
            n5_hit = r4_ez ? r4_dz
                           : (r4_un == '0) && (r4_g >= 0) && (r4_g <= r4_len);
            n5_pv  = n5_hit;
        end else if (r4_vv) begin
            n5_hit = r4_eqx;
        end else if (r4_hh) begin
            n5_hit = r4_eqy;
        end else if (r4_den == '0) begin
            // parallel lines: hit only when collinear
            n5_hit = r4_un == '0;
        end else begin
            n5_hit   = (n5_tn >= 0) && (n5_tn <= n5_den)
                    && (n5_un >= 0) && (n5_un <= n5_den);
            n5_pv    = n5_hit;
            n5_slope = n5_hit;
        end
    end

    logic               r5_vld;
    logic [DEN_W-1:0]   r5_den, r5_tn;
    logic [W-1:0]       r5_arx, r5_ary;
    t_side              r5_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_den         <= n5_den[DEN_W-1:0];
        r5_tn          <= n5_tn[DEN_W-1:0];
        r5_arx         <= r4_arx;
        r5_ary         <= r4_ary;
        r5_side.hit    <= n5_hit;
        r5_side.pv     <= n5_pv;
        r5_side.slope  <= n5_slope;
        r5_side.neg_x  <= r4_nx;
        r5_side.neg_y  <= r4_ny;
        r5_side.base_x <= r4_bx;
        r5_side.base_y <= r4_by;
    end

    // ---------------- stage 6: |r| * t partial products
    logic               r6_vld;
    logic [2*W-1:0]     r6_xlo, r6_ylo;
    logic [2*W:0]       r6_xhi, r6_yhi;
    logic [DEN_W-1:0]   r6_den;
    t_side              r6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_xlo  <= r5_arx * r5_tn[W-1:0];
        r6_xhi  <= r5_arx * r5_tn[DEN_W-1:W];
        r6_ylo  <= r5_ary * r5_tn[W-1:0];
        r6_yhi  <= r5_ary * r5_tn[DEN_W-1:W];
        r6_den  <= r5_den;
        r6_side <= r5_side;
    end

    // ---------------- rounding dividend 2|r|t + den over divisor 2 den
    logic [NW-1:0]  n6_nx, n6_ny;
    logic [DVW-1:0] n6_dv;

    always_comb begin
        n6_nx = (NW'(r6_xhi) << (W + 1)) + (NW'(r6_xlo) << 1) + NW'(r6_den);
        n6_ny = (NW'(r6_yhi) << (W + 1)) + (NW'(r6_ylo) << 1) + NW'(r6_den);
        n6_dv = {r6_den, 1'b0};
    end

    logic         div_vld_x, div_vld_y;
    logic [W-1:0] div_qx, div_qy;

    sgi_div #(
        .QW (W),
        .DW (DVW)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r6_vld),
        .i_num   (n6_nx),
        .i_den   (n6_dv),
        .o_valid (div_vld_x),
        .o_quo   (div_qx)
    );

    sgi_div #(
        .QW (W),
        .DW (DVW)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r6_vld),
        .i_num   (n6_ny),
        .i_den   (n6_dv),
        .o_valid (div_vld_y),
        .o_quo   (div_qy)
    );

    // sideband delay matching the divider latency
    t_side r_dly [W+1];

    always_ff @(posedge i_clk) begin
        r_dly[0] <= r6_side;
        for (int k = 0; k < W; k++) begin
            r_dly[k+1] <= r_dly[k];
        end
    end

    // ---------------- output stage: apply sign, offset, saturate, or pass the base point or zero
    logic signed [W+1:0] n7_sx, n7_sy, n7_ox, n7_oy;
    logic signed [W-1:0] n7_cx, n7_cy;
    t_side               n7_side;

    always_comb begin
        n7_side = r_dly[W];
        n7_ox   = n7_side.neg_x ? -$signed({2'b00, div_qx}) : $signed({2'b00, div_qx});
        n7_oy   = n7_side.neg_y ? -$signed({2'b00, div_qy}) : $signed({2'b00, div_qy});
        n7_sx   = {{2{n7_side.base_x[W-1]}}, n7_side.base_x} + n7_ox;
        n7_sy   = {{2{n7_side.base_y[W-1]}}, n7_side.base_y} + n7_oy;
        if ((n7_sx[W+1:W-1] == '0) || (n7_sx[W+1:W-1] == '1)) begin
            n7_cx = n7_sx[W-1:0];
        end else begin
            n7_cx = n7_sx[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        if ((n7_sy[W+1:W-1] == '0) || (n7_sy[W+1:W-1] == '1)) begin
            n7_cy = n7_sy[W-1:0];
        end else begin
            n7_cy = n7_sy[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        if (!n7_side.pv) begin
            n7_cx = '0;
            n7_cy = '0;
        end else if (!n7_side.slope) begin
            n7_cx = n7_side.base_x;
            n7_cy = n7_side.base_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= div_vld_x & div_vld_y;
        end
    end

    always_ff @(posedge i_clk) begin
        o_hit         <= n7_side.hit;
        o_point_valid <= n7_side.pv;
        o_cross_x     <= n7_cx;
        o_cross_y     <= n7_cy;
    end

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int CW = sgi_pkg::COORD_WIDTH_DEF;
    localparam int N_RANDOM = 830;
    localparam int SETTLE_CYCLES = CW + 20;
    localparam int STALL_LIMIT = 5000;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        coord_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    } seg_pair_t;

    typedef struct packed {
        logic   hit;
        logic   point_valid;
        coord_t cross_x;
        coord_t cross_y;
    } crossing_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    seg_pair_t cur = '0;
    logic o_done, o_hit, o_point_valid;
    coord_t o_cross_x, o_cross_y;

    seg_pair_t pending_pairs[$];
    crossing_t expected_crossings[$];
    int n_sent = 0;
    int n_checked = 0;
    int n_hits = 0;
    int n_points = 0;
    int n_mismatch = 0;
    int quiet_cycles = 0;

    segment_intersection_top #(.COORD_WIDTH(CW)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_a_start_x(cur.ax0), .i_a_start_y(cur.ay0),
        .i_a_end_x(cur.ax1), .i_a_end_y(cur.ay1),
        .i_b_start_x(cur.bx0), .i_b_start_y(cur.by0),
        .i_b_end_x(cur.bx1), .i_b_end_y(cur.by1),
        .o_done(o_done), .o_hit(o_hit), .o_point_valid(o_point_valid),
        .o_cross_x(o_cross_x), .o_cross_y(o_cross_y)
    );

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // exact geometry on wide integers
    function automatic wide_t cross2(wide_t ax, wide_t ay, wide_t bx, wide_t by);
        return ax * by - ay * bx;
    endfunction

    function automatic bit lies_on(wide_t cx, wide_t cy, wide_t px, wide_t py,
                                   wide_t rx, wide_t ry);
        wide_t dx, dy, dot, len;
        dx = cx - px;
        dy = cy - py;
        if (rx == 0 && ry == 0)
            return dx == 0 && dy == 0;
        if (cross2(dx, dy, rx, ry) != 0)
            return 1'b0;
        dot = dx * rx + dy * ry;
        len = rx * rx + ry * ry;
        return dot >= 0 && dot <= len;
    endfunction

    // nearest, ties away from zero
    function automatic wide_t round_div(wide_t n, wide_t d);
        wide_t an, ad, q;
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        q = (2 * an + ad) / (2 * ad);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic coord_t clamp_coord(wide_t v);
        wide_t hi, lo;
        hi = (wide_t'(1) <<< (CW - 1)) - 1;
        lo = -(wide_t'(1) <<< (CW - 1));
        if (v > hi) return coord_t'(hi);
        if (v < lo) return coord_t'(lo);
        return coord_t'(v);
    endfunction

    function automatic crossing_t intersect_segments(seg_pair_t s);
        wide_t px, py, qx, qy, rx, ry, sx, sy, dx, dy, den, tn, un;
        bit a_vert, a_horz, a_pt, b_vert, b_horz, b_pt;
        crossing_t res;
        res = '0;
        px = s.ax0; py = s.ay0; qx = s.bx0; qy = s.by0;
        rx = wide_t'(s.ax1) - px; ry = wide_t'(s.ay1) - py;
        sx = wide_t'(s.bx1) - qx; sy = wide_t'(s.by1) - qy;
        a_vert = s.ax0 == s.ax1; a_pt = a_vert && s.ay0 == s.ay1;
        a_horz = !a_vert && s.ay0 == s.ay1;
        b_vert = s.bx0 == s.bx1; b_pt = b_vert && s.by0 == s.by1;
        b_horz = !b_vert && s.by0 == s.by1;
        if (a_pt) begin
            res.hit = lies_on(px, py, qx, qy, sx, sy);
            if (res.hit) begin
                res.point_valid = 1'b1; res.cross_x = s.ax0; res.cross_y = s.ay0;
            end
        end else if (b_pt) begin
            res.hit = lies_on(qx, qy, px, py, rx, ry);
            if (res.hit) begin
                res.point_valid = 1'b1; res.cross_x = s.bx0; res.cross_y = s.by0;
            end
        end else if (a_vert && b_vert) begin
            res.hit = s.ax0 == s.bx0;
        end else if (a_horz && b_horz) begin
            res.hit = s.ay0 == s.by0;
        end else begin
            dx = qx - px; dy = qy - py;
            den = cross2(rx, ry, sx, sy);
            if (den == 0) begin
                res.hit = cross2(dx, dy, rx, ry) == 0;
            end else begin
                tn = cross2(dx, dy, sx, sy);
                un = cross2(dx, dy, rx, ry);
                if (den < 0) begin
                    den = -den; tn = -tn; un = -un;
                end
                res.hit = tn >= 0 && tn <= den && un >= 0 && un <= den;
                if (res.hit) begin
                    res.point_valid = 1'b1;
                    res.cross_x = clamp_coord(px + round_div(rx * tn, den));
                    res.cross_y = clamp_coord(py + round_div(ry * tn, den));
                end
            end
        end
        return res;
    endfunction

    // stimulus helpers
    function automatic coord_t any_coord();
        return coord_t'($urandom);
    endfunction

    function automatic coord_t box_coord();
        return coord_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
    endfunction

    function automatic coord_t tiny_step();
        return coord_t'(int'($urandom_range(0, 64)) - 32);
    endfunction

    function automatic seg_pair_t random_pair();
        seg_pair_t s;
        coord_t ox, oy, ddx, ddy;
        int k, j;
        s = {box_coord(), box_coord(), box_coord(), box_coord(),
             box_coord(), box_coord(), box_coord(), box_coord()};
        case ($urandom_range(0, 9))
            0, 1: begin
                s = {any_coord(), any_coord(), any_coord(), any_coord(),
                     any_coord(), any_coord(), any_coord(), any_coord()};
            end
            2: begin
                // vertical and horizontal shapes with shared values
                if ($urandom_range(0, 1)) s.ax1 = s.ax0;
                if ($urandom_range(0, 1)) s.by1 = s.by0;
                if ($urandom_range(0, 1)) s.bx1 = s.bx0;
                if ($urandom_range(0, 1)) s.ay1 = s.ay0;
                if ($urandom_range(0, 1)) s.bx0 = s.ax0;
                if ($urandom_range(0, 1)) s.by0 = s.ay0;
            end
            3, 4: begin
                // parallel or collinear along a common direction
                ox = box_coord(); oy = box_coord();
                ddx = tiny_step(); ddy = tiny_step();
                s.ax0 = ox; s.ay0 = oy;
                s.ax1 = ox + ddx * 100; s.ay1 = oy + ddy * 100;
                k = int'($urandom_range(0, 200)) - 100;
                s.bx0 = ox + ddx * k; s.by0 = oy + ddy * k;
                k = int'($urandom_range(0, 200)) - 100;
                s.bx1 = ox + ddx * k; s.by1 = oy + ddy * k;
                if ($urandom_range(0, 2) == 0) s.by0 = s.by0 + 1;
            end
            5: begin
                // a point on, or just off, the other segment
                ox = box_coord(); oy = box_coord();
                ddx = tiny_step(); ddy = tiny_step();
                k = $urandom_range(1, 1000);
                j = int'($urandom_range(0, k + 2)) - 1;
                s.ax0 = ox; s.ay0 = oy; s.ax1 = ox + ddx * k; s.ay1 = oy + ddy * k;
                s.bx0 = ox + ddx * j; s.by0 = oy + ddy * j;
                if ($urandom_range(0, 3) == 0) s.by0 = s.by0 + 1;
                s.bx1 = s.bx0; s.by1 = s.by0;
                if ($urandom_range(0, 1)) s = {s.bx0, s.by0, s.bx1, s.by1,
                                               s.ax0, s.ay0, s.ax1, s.ay1};
            end
            default: ;
        endcase
        return s;
    endfunction

    // mismatch reporting
    task automatic report(string what, logic [CW-1:0] exp_v, logic [CW-1:0] got_v);
        n_mismatch++;
        if (n_mismatch <= 10)
            $display("transaction %0d: %s expected %0d got %0d", n_checked, what,
                     $signed(exp_v), $signed(got_v));
    endtask

    // driver
    always @(posedge i_clk) begin
        int idle_pct;
        crossing_t exp_res;
        if (!i_rst_n) begin
            start <= 1'b0;
            cur <= '0;
        end else begin
            if (start && !busy) begin
                exp_res = intersect_segments(cur);
                expected_crossings.push_back(exp_res);
                n_sent++;
            end
            if (!start || !busy) begin
                if (n_sent < 300) idle_pct = 0;
                else if (n_sent < 550) idle_pct = 78;
                else if (n_sent < 700) idle_pct = 8;
                else idle_pct = 0;
                if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    cur <= pending_pairs.pop_front();
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        crossing_t exp_res;
        if (i_rst_n && o_done) begin
            if (expected_crossings.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("result with no transaction outstanding");
            end else begin
                exp_res = expected_crossings.pop_front();
                if (o_hit !== exp_res.hit) report("hit", exp_res.hit, o_hit);
                if (o_point_valid !== exp_res.point_valid)
                    report("point_valid", exp_res.point_valid, o_point_valid);
                if (o_cross_x !== exp_res.cross_x) report("cross_x", exp_res.cross_x, o_cross_x);
                if (o_cross_y !== exp_res.cross_y) report("cross_y", exp_res.cross_y, o_cross_y);
                n_hits += exp_res.hit;
                n_points += exp_res.point_valid;
            end
            n_checked++;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        coord_t mx, mn;
        mx = {1'b0, {(CW-1){1'b1}}};
        mn = {1'b1, {(CW-1){1'b0}}};
        // extremes of the fields
        pending_pairs.push_back({mn, mn, mx, mx, mn, mx, mx, mn});
        pending_pairs.push_back({mx, mx, mn, mn, mx, mn, mn, mx});
        pending_pairs.push_back({mn, mn, mn, mn, mn, mn, mx, mx});
        pending_pairs.push_back({mx, mn, mx, mn, mx, mn, mx, mn});
        pending_pairs.push_back({mn, mx, mx, mx, mx, mn, mx, mx});
        pending_pairs.push_back({{CW{1'b1}}, {CW{1'b0}}, {CW{1'b0}}, {CW{1'b1}},
                                 {CW{1'b0}}, {CW{1'b0}}, {CW{1'b1}}, {CW{1'b1}}});
        // plain crossing, and two with a rounded point
        pending_pairs.push_back({coord_t'(0), coord_t'(0), coord_t'(100), coord_t'(100),
                                 coord_t'(0), coord_t'(100), coord_t'(100), coord_t'(0)});
        pending_pairs.push_back({coord_t'(0), coord_t'(0), coord_t'(3), coord_t'(1),
                                 coord_t'(0), coord_t'(1), coord_t'(1), coord_t'(0)});
        pending_pairs.push_back({coord_t'(-5), coord_t'(0), coord_t'(0), coord_t'(-3),
                                 coord_t'(-5), coord_t'(-3), coord_t'(-1), coord_t'(0)});
        // crossing outside one segment
        pending_pairs.push_back({coord_t'(0), coord_t'(0), coord_t'(10), coord_t'(10),
                                 coord_t'(20), coord_t'(0), coord_t'(30), coord_t'(-10)});
        // point segments: on, off, on an end, equal points, distinct points
        pending_pairs.push_back({coord_t'(5), coord_t'(5), coord_t'(5), coord_t'(5),
                                 coord_t'(0), coord_t'(0), coord_t'(10), coord_t'(10)});
        pending_pairs.push_back({coord_t'(5), coord_t'(6), coord_t'(5), coord_t'(6),
                                 coord_t'(0), coord_t'(0), coord_t'(10), coord_t'(10)});
        pending_pairs.push_back({coord_t'(0), coord_t'(0), coord_t'(10), coord_t'(10),
                                 coord_t'(10), coord_t'(10), coord_t'(10), coord_t'(10)});
        pending_pairs.push_back({coord_t'(7), coord_t'(7), coord_t'(7), coord_t'(7),
                                 coord_t'(7), coord_t'(7), coord_t'(7), coord_t'(7)});
        pending_pairs.push_back({coord_t'(7), coord_t'(7), coord_t'(7), coord_t'(7),
                                 coord_t'(8), coord_t'(7), coord_t'(8), coord_t'(7)});
        // two verticals, equal and distinct x
        pending_pairs.push_back({coord_t'(3), coord_t'(0), coord_t'(3), coord_t'(5),
                                 coord_t'(3), coord_t'(50), coord_t'(3), coord_t'(60)});
        pending_pairs.push_back({coord_t'(3), coord_t'(0), coord_t'(3), coord_t'(5),
                                 coord_t'(4), coord_t'(0), coord_t'(4), coord_t'(5)});
        // two horizontals, equal and distinct y
        pending_pairs.push_back({coord_t'(0), coord_t'(9), coord_t'(5), coord_t'(9),
                                 coord_t'(70), coord_t'(9), coord_t'(80), coord_t'(9)});
        pending_pairs.push_back({coord_t'(0), coord_t'(9), coord_t'(5), coord_t'(9),
                                 coord_t'(0), coord_t'(8), coord_t'(5), coord_t'(8)});
        // vertical against horizontal, crossing
        pending_pairs.push_back({coord_t'(3), coord_t'(-5), coord_t'(3), coord_t'(5),
                                 coord_t'(-5), coord_t'(1), coord_t'(5), coord_t'(1)});
        // parallel sloped: coincident lines apart, and distinct lines
        pending_pairs.push_back({coord_t'(0), coord_t'(0), coord_t'(2), coord_t'(1),
                                 coord_t'(10), coord_t'(5), coord_t'(12), coord_t'(6)});
        pending_pairs.push_back({coord_t'(0), coord_t'(0), coord_t'(2), coord_t'(1),
                                 coord_t'(0), coord_t'(1), coord_t'(2), coord_t'(2)});
        // touching at an endpoint
        pending_pairs.push_back({coord_t'(0), coord_t'(0), coord_t'(4), coord_t'(4),
                                 coord_t'(4), coord_t'(4), coord_t'(9), coord_t'(1)});
        for (int i = 0; i < N_RANDOM; i++)
            pending_pairs.push_back(random_pair());

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_pairs.size() == 0 && !start && expected_crossings.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d segment pairs checked: %0d hits, %0d with a crossing point",
                 n_checked, n_hits, n_points);
        $display("covered extremes, point, vertical, horizontal and parallel cases");
        if (n_mismatch == 0 && expected_crossings.size() == 0 && n_checked == n_sent) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/sgi_pkg.sv
src/sgi_div.sv
src/segment_intersection_top.sv
test/testbench.sv
